### sv/clie_pkg.sv
// Shared constants for the cursor list insert engine.
package clie_pkg;

	localparam int KIND_W = 1;
	localparam int POS_W = 8;
	localparam int CHAR_W = 8;
	localparam int STATUS_W = 2;
	localparam int ORD_W = 4;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_OK = 2'd0;
	localparam status_t STATUS_BAD_POS = 2'd1;
	localparam status_t STATUS_FULL = 2'd2;
	localparam status_t STATUS_EMPTY = 2'd3;

	localparam logic [KIND_W-1:0] KIND_INSERT = 1'b0;
	localparam logic [KIND_W-1:0] KIND_READOUT = 1'b1;

endpackage

### sv/cursor_list_insert_engine_top.sv
// Cursor list insert engine: a static linked list of bytes kept in a node memory.
//
// Request channel (req_valid, req_stall, kind, position, element): kind selects an insert
// of element at the 1-based position, or a readout of the whole list. The engine works on
// one request at a time and stalls the request channel until that request is finished.
// Response channel (rsp_valid, rsp_stall, status, char_out, ordinal, last): an insert
// gives one beat; a readout gives one beat per element, or one empty beat, with last set
// on the final beat. A response beat waits in an output register while rsp_stall is high,
// and the engine halts in place until that register is free again.
// Every step is at most one read of the link memory. An insert does a length walk, a free
// slot take, a predecessor walk and two link writes; a readout walks the list once from the
// head and gives one beat per element in list order, as the output register frees up.
// After reset the link memory reads as its initial state at once (free chain through
// all data slots, list empty) through per-entry valid flags; no clearing pass is needed.
module cursor_list_insert_engine_top #(
	parameter int NODES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [clie_pkg::KIND_W-1:0]   kind,
	input  logic [clie_pkg::POS_W-1:0]    position,
	input  logic [clie_pkg::CHAR_W-1:0]   element,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [clie_pkg::STATUS_W-1:0] status,
	output logic [clie_pkg::CHAR_W-1:0]   char_out,
	output logic [clie_pkg::ORD_W-1:0]    ordinal,
	output logic                          last
);

	localparam int IW = $clog2(NODES);
	localparam int CW = IW + 1;
	localparam logic [IW-1:0] HEAD = IW'(NODES - 1);
	localparam logic [IW-1:0] FREE_HEAD = '0;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LEN = 4'd1;
	localparam logic [3:0] ST_FREE = 4'd2;
	localparam logic [3:0] ST_TAKE = 4'd3;
	localparam logic [3:0] ST_PRED = 4'd4;
	localparam logic [3:0] ST_LINK = 4'd5;
	localparam logic [3:0] ST_JOIN = 4'd6;
	localparam logic [3:0] ST_RD = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	function automatic logic [IW-1:0] reset_link(input logic [IW-1:0] a);
		if (int'(a) < NODES - 2) begin
			reset_link = a + IW'(1);
		end else begin
			reset_link = '0;
		end
	endfunction

	logic [IW-1:0] link_mem [NODES];
	logic [clie_pkg::CHAR_W-1:0] char_mem [NODES];
	logic [NODES-1:0] link_vld_q;

	logic [IW-1:0] link_rd_q;
	logic [IW-1:0] rd_addr_q;
	logic rd_vld_q;
	logic [clie_pkg::CHAR_W-1:0] char_rd_q;

	logic [3:0] state_q, state_d;
	logic [clie_pkg::POS_W-1:0] pos_q;
	logic [clie_pkg::CHAR_W-1:0] elem_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] slot_q, slot_d;
	logic [IW-1:0] pred_q, pred_d;

	logic rsp_valid_q;
	clie_pkg::status_t status_q;
	logic [clie_pkg::CHAR_W-1:0] char_q;
	logic [clie_pkg::ORD_W-1:0] ord_q;
	logic last_q;

	logic re, we, cwe, ld, accept, out_free, bad_pos, emit_last;
	logic [IW-1:0] ra, wa, wd;
	logic [IW-1:0] lnk;
	clie_pkg::status_t ld_status;
	logic [clie_pkg::CHAR_W-1:0] ld_char;
	logic [clie_pkg::ORD_W-1:0] ld_ord;
	logic ld_last;

	assign lnk = rd_vld_q ? link_rd_q : reset_link(rd_addr_q);
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign bad_pos = (pos_q == '0) || (16'(pos_q) > 16'(cnt_q) + 16'd1);
	assign emit_last = (lnk == '0) || (16'(cnt_q) + 16'd1 >= 16'(NODES - 2));

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		slot_d = slot_q;
		pred_d = pred_q;
		re = 1'b0;
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = '0;
		cwe = 1'b0;
		ld = 1'b0;
		ld_status = clie_pkg::STATUS_OK;
		ld_char = '0;
		ld_ord = '0;
		ld_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					re = 1'b1;
					ra = HEAD;
					cnt_d = '0;
					state_d = (kind == clie_pkg::KIND_INSERT) ? ST_LEN : ST_RD;
				end
			end
			ST_LEN: begin
				if (lnk != '0) begin
					cnt_d = cnt_q + CW'(1);
					re = 1'b1;
					ra = lnk;
				end else if (bad_pos) begin
					if (out_free) begin
						ld = 1'b1;
						ld_status = clie_pkg::STATUS_BAD_POS;
						state_d = ST_IDLE;
					end
				end else begin
					re = 1'b1;
					ra = FREE_HEAD;
					state_d = ST_FREE;
				end
			end
			ST_FREE: begin
				if (lnk == '0) begin
					if (out_free) begin
						ld = 1'b1;
						ld_status = clie_pkg::STATUS_FULL;
						state_d = ST_IDLE;
					end
				end else begin
					slot_d = lnk;
					re = 1'b1;
					ra = lnk;
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				we = 1'b1;
				wa = FREE_HEAD;
				wd = lnk;
				cwe = 1'b1;
				pred_d = HEAD;
				cnt_d = '0;
				re = 1'b1;
				ra = HEAD;
				state_d = (pos_q == clie_pkg::POS_W'(1)) ? ST_LINK : ST_PRED;
			end
			ST_PRED: begin
				pred_d = lnk;
				cnt_d = cnt_q + CW'(1);
				re = 1'b1;
				ra = lnk;
				if (16'(cnt_q) + 16'd1 == 16'(pos_q) - 16'd1) begin
					state_d = ST_LINK;
				end
			end
			ST_LINK: begin
				we = 1'b1;
				wa = slot_q;
				wd = lnk;
				state_d = ST_JOIN;
			end
			ST_JOIN: begin
				if (out_free) begin
					we = 1'b1;
					wa = pred_q;
					wd = slot_q;
					ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				if (lnk == '0) begin
					if (out_free) begin
						ld = 1'b1;
						ld_status = clie_pkg::STATUS_EMPTY;
						state_d = ST_IDLE;
					end
				end else begin
					re = 1'b1;
					ra = lnk;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld = 1'b1;
					ld_char = char_rd_q;
					ld_ord = clie_pkg::ORD_W'(cnt_q + CW'(1));
					ld_last = emit_last;
					if (emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q + CW'(1);
						re = 1'b1;
						ra = lnk;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[wa] <= wd;
		end
		if (cwe) begin
			char_mem[slot_q] <= elem_q;
		end
		if (re) begin
			link_rd_q <= link_mem[ra];
			char_rd_q <= char_mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= position;
			elem_q <= element;
		end
		cnt_q <= cnt_d;
		slot_q <= slot_d;
		pred_q <= pred_d;
		if (ld) begin
			status_q <= ld_status;
			char_q <= ld_char;
			ord_q <= ld_ord;
			last_q <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			link_vld_q <= '0;
			rd_vld_q <= 1'b0;
			rd_addr_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (we) begin
				link_vld_q[wa] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= link_vld_q[ra];
				rd_addr_q <= ra;
			end
			if (ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign char_out = char_q;
	assign ordinal = ord_q;
	assign last = last_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (wa != ra))
		else $error("link memory read and write hit the same slot");

	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (wa != FREE_HEAD)) |-> (wd != wa))
		else $error("a node was linked to itself");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && ld_last) |=> (state_q == ST_IDLE))
		else $error("final beat loaded but engine did not return to idle");

	a_error_beat_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && (ld_status != clie_pkg::STATUS_OK)) |-> (ld_last && (ld_ord == '0)
			&& (ld_char == '0)))
		else $error("error beat carries data or is not final");

endmodule

### test/cursor_list_insert_engine_top_test.sv
// Self-checking testbench for the cursor list insert engine, with a shadow list predictor.
`timescale 1ns / 100ps

module cursor_list_insert_engine_top_test;

	localparam int NODES = 16;
	localparam int HEAD_SLOT = NODES - 1;
	localparam int DATA_SLOTS = NODES - 2;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE_CYCLES = 2 * NODES + 8;

	typedef struct {
		clie_pkg::status_t           status;
		logic [clie_pkg::CHAR_W-1:0] char_out;
		logic [clie_pkg::ORD_W-1:0]  ordinal;
		logic                        last;
	} rsp_beat_t;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	logic [clie_pkg::KIND_W-1:0]   kind;
	logic [clie_pkg::POS_W-1:0]    position;
	logic [clie_pkg::CHAR_W-1:0]   element;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [clie_pkg::STATUS_W-1:0] status;
	logic [clie_pkg::CHAR_W-1:0]   char_out;
	logic [clie_pkg::ORD_W-1:0]    ordinal;
	logic                          last;

	int        shadow_link [NODES];
	logic [7:0] shadow_char [NODES];
	rsp_beat_t pending_beats [$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 0;
	bit hold_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	cursor_list_insert_engine_top #(
		.NODES(NODES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.position(position),
		.element(element),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.char_out(char_out),
		.ordinal(ordinal),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int shadow_next(int slot);
		if (slot < 0 || slot >= NODES || shadow_link[slot] >= NODES)
			return 0;
		return shadow_link[slot];
	endfunction

	function automatic int shadow_length();
		int count;
		int cur;
		count = 0;
		cur = shadow_next(HEAD_SLOT);
		while (cur != 0 && count < DATA_SLOTS) begin
			count++;
			cur = shadow_next(cur);
		end
		return count;
	endfunction

	function automatic void expect_beat(clie_pkg::status_t st, int ch, int ord, bit fin);
		rsp_beat_t b;
		b.status = st;
		b.char_out = ch[clie_pkg::CHAR_W-1:0];
		b.ordinal = ord[clie_pkg::ORD_W-1:0];
		b.last = fin;
		pending_beats.push_back(b);
	endfunction

	// Applies one accepted request to the shadow list and queues the beats it must produce.
	function automatic void apply_to_shadow_list(logic [clie_pkg::KIND_W-1:0] k, int p,
		logic [7:0] e);
		int len;
		int slot;
		int pred;
		int cur;
		int nxt;
		int n;
		if (k == clie_pkg::KIND_INSERT) begin
			len = shadow_length();
			if (p < 1 || p > len + 1) begin
				expect_beat(clie_pkg::STATUS_BAD_POS, 0, 0, 1'b1);
				return;
			end
			slot = shadow_next(0);
			if (slot == 0 || slot == HEAD_SLOT) begin
				expect_beat(clie_pkg::STATUS_FULL, 0, 0, 1'b1);
				return;
			end
			shadow_link[0] = shadow_next(slot);
			shadow_char[slot] = e;
			pred = HEAD_SLOT;
			for (int i = 1; i < p; i++)
				pred = shadow_next(pred);
			shadow_link[slot] = shadow_next(pred);
			shadow_link[pred] = slot;
			expect_beat(clie_pkg::STATUS_OK, 0, 0, 1'b1);
		end else begin
			n = 0;
			cur = shadow_next(HEAD_SLOT);
			if (cur == 0) begin
				expect_beat(clie_pkg::STATUS_EMPTY, 0, 0, 1'b1);
				return;
			end
			while (cur != 0 && n < DATA_SLOTS) begin
				nxt = shadow_next(cur);
				expect_beat(clie_pkg::STATUS_OK, int'(shadow_char[cur]), n + 1,
					(nxt == 0 || n + 1 >= DATA_SLOTS));
				n++;
				cur = nxt;
			end
		end
	endfunction

	task automatic send_beat(logic [clie_pkg::KIND_W-1:0] k, logic [7:0] p, logic [7:0] e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		position <= p;
		element <= e;
		do
			@(posedge clk);
		while (req_stall);
		apply_to_shadow_list(k, int'(p), e);
	endtask

	task automatic sender_rest();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic drain_pending();
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		int len;
		int roll;
		logic [7:0] p;
		len = shadow_length();
		roll = $urandom_range(99);
		if (roll < 25) begin
			send_beat(clie_pkg::KIND_READOUT, 8'($urandom), 8'($urandom));
		end else begin
			roll = $urandom_range(99);
			if (roll < 70)
				p = 8'($urandom_range(len + 1, 1));
			else if (roll < 80)
				p = 8'd0;
			else
				p = 8'($urandom_range(255, len + 2));
			send_beat(clie_pkg::KIND_INSERT, p, 8'($urandom));
		end
	endtask

	task automatic note_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// The valid insert positions here build a short list through head, tail and middle; the rest are out of range.
	task automatic test_basic();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_beat(clie_pkg::KIND_READOUT, 8'd0, 8'd0);
		send_beat(clie_pkg::KIND_INSERT, 8'd0, 8'h11);
		send_beat(clie_pkg::KIND_INSERT, 8'd2, 8'h22);
		send_beat(clie_pkg::KIND_INSERT, 8'd255, 8'h33);
		send_beat(clie_pkg::KIND_INSERT, 8'd1, 8'h00);
		send_beat(clie_pkg::KIND_INSERT, 8'd1, 8'hFF);
		send_beat(clie_pkg::KIND_INSERT, 8'd3, 8'hAA);
		send_beat(clie_pkg::KIND_INSERT, 8'd2, 8'h55);
		send_beat(clie_pkg::KIND_INSERT, 8'd6, 8'h66);
		send_beat(clie_pkg::KIND_INSERT, 8'd5, 8'h7E);
		send_beat(clie_pkg::KIND_READOUT, 8'hFF, 8'hFF);
		sender_rest();
		drain_pending();
	endtask

	task automatic test_random_phase(int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < ITEMS_PER_PHASE; i++)
			send_random_item();
		sender_rest();
		drain_pending();
	endtask

	// A full list must report a bad position before it reports that no slot is free.
	task automatic test_full_list();
		send_idle_pct = 10;
		recv_stall_pct = 10;
		while (shadow_length() < DATA_SLOTS)
			send_beat(clie_pkg::KIND_INSERT, 8'($urandom_range(shadow_length() + 1, 1)),
				8'($urandom));
		send_beat(clie_pkg::KIND_INSERT, 8'd1, 8'h5A);
		send_beat(clie_pkg::KIND_INSERT, 8'(DATA_SLOTS + 1), 8'hA5);
		send_beat(clie_pkg::KIND_INSERT, 8'd0, 8'h01);
		send_beat(clie_pkg::KIND_INSERT, 8'(DATA_SLOTS + 2), 8'h02);
		send_beat(clie_pkg::KIND_READOUT, 8'd0, 8'd0);
		sender_rest();
		drain_pending();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		for (int i = 0; i < 8; i++)
			send_beat(clie_pkg::KIND_READOUT, 8'($urandom), 8'($urandom));
		send_beat(clie_pkg::KIND_INSERT, 8'd0, 8'h00);
		hold_go = 1'b0;
		sender_rest();
		drain_pending();
	endtask

	always @(negedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_left = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (!hold_go)
			hold_taken = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_beats.size() == 0) begin
				note_mismatch("unexpected beat, status", 0, int'(status));
			end else begin
				want = pending_beats.pop_front();
				if (status !== want.status)
					note_mismatch("status", int'(want.status), int'(status));
				if (char_out !== want.char_out)
					note_mismatch("char_out", int'(want.char_out), int'(char_out));
				if (ordinal !== want.ordinal)
					note_mismatch("ordinal", int'(want.ordinal), int'(ordinal));
				if (last !== want.last)
					note_mismatch("last", int'(want.last), int'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		kind = clie_pkg::KIND_INSERT;
		position = '0;
		element = '0;
		for (int i = 0; i < NODES; i++) begin
			shadow_link[i] = 0;
			shadow_char[i] = 8'h00;
		end
		for (int i = 0; i + 2 < NODES; i++)
			shadow_link[i] = i + 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic();
		test_random_phase(0, 0);
		test_random_phase(69, 0);
		test_random_phase(0, 69);
		test_random_phase(10, 10);
		test_full_list();
		test_backpressure();

		drain_pending();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
